>>> rtl/core/blpn_pkg.sv
// ----------------------------------------------------------------------------
// blpn_pkg
// Shared types and constants for the band level peak normalizer.
// ----------------------------------------------------------------------------
package blpn_pkg;

    localparam int NUM_BANDS   = 3;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int FLOOR_W     = 32;
    localparam int DECAY_W     = 16;
    localparam int KEEP_W      = 17;
    localparam int KEEP_FRAC   = 16;
    localparam int KEEP_ONE    = 65536;
    localparam int KEEP_HALF   = 32768;

    // Reset values of the tracked peaks, integer energy units
    localparam int BASS_PEAK_INIT   = 240000;
    localparam int MID_PEAK_INIT    = 200000;
    localparam int TREBLE_PEAK_INIT = 180000;

    localparam logic [FLOOR_W-1:0] BASS_FLOOR_RST   = FLOOR_W'(120000);
    localparam logic [FLOOR_W-1:0] MID_FLOOR_RST    = FLOOR_W'(100000);
    localparam logic [FLOOR_W-1:0] TREBLE_FLOOR_RST = FLOOR_W'(90000);
    localparam logic [DECAY_W-1:0] BASS_DECAY_RST   = DECAY_W'(1600);
    localparam logic [DECAY_W-1:0] MID_DECAY_RST    = DECAY_W'(1333);
    localparam logic [DECAY_W-1:0] TREBLE_DECAY_RST = DECAY_W'(1200);
    localparam logic [KEEP_W-1:0]  SMOOTH_KEEP_RST  = KEEP_W'(39322);

    typedef logic [1:0] band_idx_t;

    localparam band_idx_t BAND_BASS   = 2'd0;
    localparam band_idx_t BAND_MID    = 2'd1;
    localparam band_idx_t BAND_TREBLE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASS_FLOOR   = 3'd0,
        REG_MID_FLOOR    = 3'd1,
        REG_TREBLE_FLOOR = 3'd2,
        REG_BASS_DECAY   = 3'd3,
        REG_MID_DECAY    = 3'd4,
        REG_TREBLE_DECAY = 3'd5,
        REG_SMOOTH_KEEP  = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEAK,
        ST_DIV,
        ST_DECAY,
        ST_MAC,
        ST_STORE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic      load_in;
        logic      peak_init;
        logic      div_step;
        logic      decay;
        logic      mac;
        logic      store;
        logic      out_load;
        band_idx_t band;
    } cmd_t;

endpackage

>>> rtl/core/blpn_datapath.sv
// ----------------------------------------------------------------------------
// blpn_datapath
// Band registers, shared restoring divider, peak decay and smoothing MAC.
// ----------------------------------------------------------------------------
module blpn_datapath
    import blpn_pkg::*;
#(
    parameter int ENERGY_WIDTH    = 32,
    parameter int PEAK_FRAC_BITS  = 4,
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  cmd_t                       cmd,
    input  logic [ENERGY_WIDTH-1:0]    bass_energy,
    input  logic [ENERGY_WIDTH-1:0]    mid_energy,
    input  logic [ENERGY_WIDTH-1:0]    treble_energy,
    output logic [LEVEL_FRAC_BITS:0]   bass_level,
    output logic [LEVEL_FRAC_BITS:0]   mid_level,
    output logic [LEVEL_FRAC_BITS:0]   treble_level,
    output logic [LEVEL_FRAC_BITS:0]   bass_smoothed,
    output logic [LEVEL_FRAC_BITS:0]   mid_smoothed,
    output logic [LEVEL_FRAC_BITS:0]   treble_smoothed
);

    localparam int LW   = LEVEL_FRAC_BITS + 1;
    localparam int PKW  = ((ENERGY_WIDTH > 18) ? ENERGY_WIDTH : 18) + PEAK_FRAC_BITS;
    localparam int CMPW = ((ENERGY_WIDTH > FLOOR_W) ? ENERGY_WIDTH : FLOOR_W)
                          + PEAK_FRAC_BITS;
    localparam int AW   = LW + KEEP_W + 1;

    logic [ENERGY_WIDTH-1:0] energy_reg [NUM_BANDS];
    logic [PKW-1:0]          peak_reg   [NUM_BANDS];
    logic [LW-1:0]           smooth_reg [NUM_BANDS];
    logic [LW-1:0]           level_reg  [NUM_BANDS];
    logic [FLOOR_W-1:0]      floor_reg  [NUM_BANDS];
    logic [DECAY_W-1:0]      decay_reg  [NUM_BANDS];
    logic [KEEP_W-1:0]       keep_reg;

    logic [PKW-1:0]          p_reg;
    logic [PKW-1:0]          rem_reg;
    logic [LW-1:0]           q_reg;
    logic [AW-1:0]           acc_reg;

    logic [LW-1:0]           bass_level_reg, mid_level_reg, treble_level_reg;
    logic [LW-1:0]           bass_smoothed_reg, mid_smoothed_reg, treble_smoothed_reg;

    logic [PKW-1:0]    eq;
    logic [PKW-1:0]    peak_cur;
    logic [PKW-1:0]    peak_max;
    logic              q_first;
    logic [PKW:0]      rem2;
    logic              rem_ge;
    logic [PKW:0]      rem_sub;
    logic [CMPW-1:0]   floor_ext;
    logic [CMPW-1:0]   p_ext;
    logic [PKW-1:0]    decay_ext;
    logic [PKW-1:0]    peak_decayed;
    logic [KEEP_W-1:0] keep_c;
    logic [KEEP_W-1:0] keep_new;

    always_comb
    begin
        eq        = PKW'(energy_reg[cmd.band]) << PEAK_FRAC_BITS;
        peak_cur  = peak_reg[cmd.band];
        peak_max  = (eq > peak_cur) ? eq : peak_cur;
        // eq never exceeds the updated peak, so the integer bit is set only on a tie
        q_first   = (eq == peak_max);

        rem2      = {rem_reg, 1'b0};
        rem_ge    = (rem2 >= {1'b0, p_reg});
        rem_sub   = rem2 - {1'b0, p_reg};

        floor_ext = CMPW'(floor_reg[cmd.band]) << PEAK_FRAC_BITS;
        p_ext     = CMPW'(p_reg);
        decay_ext = PKW'(decay_reg[cmd.band]);
        // saturate at one LSB so the next divisor is never zero
        peak_decayed = (p_reg > decay_ext) ? (p_reg - decay_ext) : PKW'(1);

        keep_c    = (keep_reg > KEEP_W'(KEEP_ONE)) ? KEEP_W'(KEEP_ONE) : keep_reg;
        keep_new  = KEEP_W'(KEEP_ONE) - keep_c;
    end

    // configuration registers and band state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg[BAND_BASS]   <= BASS_FLOOR_RST;
            floor_reg[BAND_MID]    <= MID_FLOOR_RST;
            floor_reg[BAND_TREBLE] <= TREBLE_FLOOR_RST;
            decay_reg[BAND_BASS]   <= BASS_DECAY_RST;
            decay_reg[BAND_MID]    <= MID_DECAY_RST;
            decay_reg[BAND_TREBLE] <= TREBLE_DECAY_RST;
            keep_reg               <= SMOOTH_KEEP_RST;
            peak_reg[BAND_BASS]    <= PKW'(BASS_PEAK_INIT) << PEAK_FRAC_BITS;
            peak_reg[BAND_MID]     <= PKW'(MID_PEAK_INIT) << PEAK_FRAC_BITS;
            peak_reg[BAND_TREBLE]  <= PKW'(TREBLE_PEAK_INIT) << PEAK_FRAC_BITS;
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                smooth_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_BASS_FLOOR:   floor_reg[BAND_BASS]   <= cfg_data[FLOOR_W-1:0];
                    REG_MID_FLOOR:    floor_reg[BAND_MID]    <= cfg_data[FLOOR_W-1:0];
                    REG_TREBLE_FLOOR: floor_reg[BAND_TREBLE] <= cfg_data[FLOOR_W-1:0];
                    REG_BASS_DECAY:   decay_reg[BAND_BASS]   <= cfg_data[DECAY_W-1:0];
                    REG_MID_DECAY:    decay_reg[BAND_MID]    <= cfg_data[DECAY_W-1:0];
                    REG_TREBLE_DECAY: decay_reg[BAND_TREBLE] <= cfg_data[DECAY_W-1:0];
                    REG_SMOOTH_KEEP:  keep_reg               <= cfg_data[KEEP_W-1:0];
                    default:          ;
                endcase
            end

            if (cmd.peak_init)
            begin
                peak_reg[cmd.band] <= peak_max;
            end
            else if (cmd.decay && (p_ext > floor_ext))
            begin
                peak_reg[cmd.band] <= peak_decayed;
            end

            if (cmd.store)
            begin
                smooth_reg[cmd.band] <= acc_reg[KEEP_FRAC +: LW];
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            energy_reg[BAND_BASS]   <= bass_energy;
            energy_reg[BAND_MID]    <= mid_energy;
            energy_reg[BAND_TREBLE] <= treble_energy;
        end

        if (cmd.peak_init)
        begin
            p_reg   <= peak_max;
            rem_reg <= q_first ? '0 : eq;
            q_reg   <= LW'(q_first);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[PKW-1:0] : rem2[PKW-1:0];
            q_reg   <= {q_reg[LW-2:0], rem_ge};
        end

        if (cmd.decay)
        begin
            level_reg[cmd.band] <= q_reg;
            acc_reg <= AW'(keep_c) * AW'(smooth_reg[cmd.band]) + AW'(KEEP_HALF);
        end
        else if (cmd.mac)
        begin
            acc_reg <= acc_reg + AW'(keep_new) * AW'(level_reg[cmd.band]);
        end

        if (cmd.out_load)
        begin
            bass_level_reg      <= level_reg[BAND_BASS];
            mid_level_reg       <= level_reg[BAND_MID];
            treble_level_reg    <= level_reg[BAND_TREBLE];
            bass_smoothed_reg   <= smooth_reg[BAND_BASS];
            mid_smoothed_reg    <= smooth_reg[BAND_MID];
            treble_smoothed_reg <= smooth_reg[BAND_TREBLE];
        end
    end

    assign bass_level      = bass_level_reg;
    assign mid_level       = mid_level_reg;
    assign treble_level    = treble_level_reg;
    assign bass_smoothed   = bass_smoothed_reg;
    assign mid_smoothed    = mid_smoothed_reg;
    assign treble_smoothed = treble_smoothed_reg;

endmodule

>>> rtl/core/blpn_controller.sv
// ----------------------------------------------------------------------------
// blpn_controller
// Sequencer that walks the three bands through peak, divide, decay, smooth.
// ----------------------------------------------------------------------------
module blpn_controller
    import blpn_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    localparam int IW = $clog2(LEVEL_FRAC_BITS);

    state_t          state_reg, state_next;
    band_idx_t       band_reg, band_next;
    logic [IW-1:0]   iter_reg, iter_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_reg      <= BAND_BASS;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            band_reg      <= band_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        band_next      = band_reg;
        iter_next      = iter_reg;
        cmd            = '0;
        cmd.band       = band_reg;
        // drop the held result once the transaction completes
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    band_next   = BAND_BASS;
                    state_next  = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                cmd.peak_init = 1'b1;
                iter_next     = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (iter_reg == IW'(LEVEL_FRAC_BITS - 1))
                begin
                    state_next = ST_DECAY;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_DECAY:
            begin
                cmd.decay  = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac    = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (band_reg == BAND_TREBLE)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    band_next  = band_reg + 1'b1;
                    state_next = ST_PEAK;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/band_level_peak_normalizer_top.sv
// ----------------------------------------------------------------------------
// band_level_peak_normalizer_top
// Per-band peak tracking normalizer with exponential level smoothing.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_stall   bass_energy, mid_energy, treble_energy
//  out      out_valid / out_stall bass/mid/treble_level, bass/mid/treble_smoothed
//  cfg      cfg_write             cfg_index, cfg_data (no read-back)
//
//  A transaction walks the three bands in turn through the single restoring
//  divider that they share, one quotient bit per cycle, followed by decay and
//  a smoothing MAC that scales the old smoothed level and adds the new level.
//  in_stall is high from accept until the result moves to the output register;
//  a result held under out_stall does not block the next input transaction.
//  Reset loads the register defaults, the initial peaks and zero smoothed levels.
// ----------------------------------------------------------------------------
module band_level_peak_normalizer_top
    import blpn_pkg::*;
#(
    parameter int ENERGY_WIDTH    = 32,
    parameter int PEAK_FRAC_BITS  = 4,
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ENERGY_WIDTH-1:0]  bass_energy,
    input  logic [ENERGY_WIDTH-1:0]  mid_energy,
    input  logic [ENERGY_WIDTH-1:0]  treble_energy,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [LEVEL_FRAC_BITS:0] bass_level,
    output logic [LEVEL_FRAC_BITS:0] mid_level,
    output logic [LEVEL_FRAC_BITS:0] treble_level,
    output logic [LEVEL_FRAC_BITS:0] bass_smoothed,
    output logic [LEVEL_FRAC_BITS:0] mid_smoothed,
    output logic [LEVEL_FRAC_BITS:0] treble_smoothed
);

    cmd_t cmd;

    blpn_controller #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    blpn_datapath #(
        .ENERGY_WIDTH    (ENERGY_WIDTH),
        .PEAK_FRAC_BITS  (PEAK_FRAC_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .bass_energy     (bass_energy),
        .mid_energy      (mid_energy),
        .treble_energy   (treble_energy),
        .bass_level      (bass_level),
        .mid_level       (mid_level),
        .treble_level    (treble_level),
        .bass_smoothed   (bass_smoothed),
        .mid_smoothed    (mid_smoothed),
        .treble_smoothed (treble_smoothed)
    );

endmodule
